/* hw/rtl/upr_pkg.sv */
// ----------------------------------------------------------------------------
// upr_pkg
// Shared types, pattern tables and match helpers for the punctuation replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package upr_pkg;

  localparam int PAT_COUNT = 10;
  localparam int PAT_IDX_W = 4;

  // Three-byte sequences, first byte in the top octet
  localparam logic [23:0] PAT_SEQ [PAT_COUNT] = '{
    24'hEFBC8C, 24'hEFBC9A, 24'hEFBC9B, 24'hE38090, 24'hE38091,
    24'hEFBC88, 24'hEFBC89, 24'hEFBC9F, 24'hEFBC81, 24'hE280A6
  };

  // ASCII replacements, first byte in the top octet
  localparam logic [23:0] REP_SEQ [PAT_COUNT] = '{
    24'h2C2000, 24'h3A2000, 24'h3B2000, 24'h5B0000, 24'h5D0000,
    24'h280000, 24'h290000, 24'h3F2000, 24'h212000, 24'h2E2E2E
  };

  localparam logic [1:0] REP_LEN [PAT_COUNT] = '{
    2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
  };

  // Bytes emitted by one input item, data[0] goes out first
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            eot;
  } group_t;

  // Front to queue request
  typedef struct packed {
    logic   push;
    group_t grp;
  } push_req_t;

  typedef struct packed {
    logic                 hit;
    logic [PAT_IDX_W-1:0] idx;
  } match_t;

  // One-byte prefix of some sequence
  function automatic logic is_p1(logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      if (PAT_SEQ[i][23:16] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // Two-byte prefix of some sequence
  function automatic logic is_p2(logic [7:0] a, logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PAT_COUNT; i++) begin
      if (PAT_SEQ[i][23:8] == {a, b}) hit = 1'b1;
    end
    return hit;
  endfunction

  // Full match, lowest index wins
  function automatic match_t match3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    match_t m;
    m = '0;
    for (int i = PAT_COUNT - 1; i >= 0; i--) begin
      if (PAT_SEQ[i] == {a, b, c}) begin
        m.hit = 1'b1;
        m.idx = PAT_IDX_W'(i);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/upr_front.sv */
// ----------------------------------------------------------------------------
// upr_front
// Holds the pending prefix bytes and turns each input item into a group of
// zero to three output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module upr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         in_byte,
  input  wire logic               end_of_text,
  output upr_pkg::push_req_t      req
);

  logic [1:0] held_count, held_count_next;
  logic [7:0] held0, held0_next;
  logic [7:0] held1, held1_next;
  upr_pkg::group_t grp;
  upr_pkg::match_t m;

  assign m = upr_pkg::match3(held0, held1, in_byte);

  // Greedy scan over held bytes plus the new byte
  always_comb begin
    grp             = '0;
    grp.eot         = end_of_text;
    held_count_next = held_count;
    held0_next      = held0;
    held1_next      = held1;
    case (held_count)
      2'd1: begin
        if (end_of_text) begin
          grp.data[0] = held0;
          grp.data[1] = in_byte;
          grp.cnt = 2'd2;
          held_count_next = 2'd0;
        end else if (upr_pkg::is_p2(held0, in_byte)) begin
          held1_next = in_byte;
          held_count_next = 2'd2;
        end else if (upr_pkg::is_p1(in_byte)) begin
          grp.data[0] = held0;
          grp.cnt = 2'd1;
          held0_next = in_byte;
        end else begin
          grp.data[0] = held0;
          grp.data[1] = in_byte;
          grp.cnt = 2'd2;
          held_count_next = 2'd0;
        end
      end
      2'd2: begin
        if (m.hit) begin
          grp.data[0] = upr_pkg::REP_SEQ[m.idx][23:16];
          grp.data[1] = upr_pkg::REP_SEQ[m.idx][15:8];
          grp.data[2] = upr_pkg::REP_SEQ[m.idx][7:0];
          grp.cnt = upr_pkg::REP_LEN[m.idx];
          held_count_next = 2'd0;
        end else if (!end_of_text && upr_pkg::is_p2(held1, in_byte)) begin
          grp.data[0] = held0;
          grp.cnt = 2'd1;
          held0_next = held1;
          held1_next = in_byte;
        end else if (!end_of_text && upr_pkg::is_p1(in_byte)) begin
          grp.data[0] = held0;
          grp.data[1] = held1;
          grp.cnt = 2'd2;
          held0_next = in_byte;
          held_count_next = 2'd1;
        end else begin
          grp.data[0] = held0;
          grp.data[1] = held1;
          grp.data[2] = in_byte;
          grp.cnt = 2'd3;
          held_count_next = 2'd0;
        end
      end
      default: begin
        // nothing held
        if (!end_of_text && upr_pkg::is_p1(in_byte)) begin
          held0_next = in_byte;
          held_count_next = 2'd1;
        end else begin
          grp.data[0] = in_byte;
          grp.cnt = 2'd1;
          held_count_next = 2'd0;
        end
      end
    endcase
  end

  assign req.push = accept && (grp.cnt != 2'd0);
  assign req.grp  = grp;

  // Held prefix state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upr_queue.sv */
// ----------------------------------------------------------------------------
// upr_queue
// Small queue of byte groups between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module upr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire upr_pkg::push_req_t req,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output upr_pkg::group_t        head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upr_pkg::group_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = req.push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= req.grp;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upr_back.sv */
// ----------------------------------------------------------------------------
// upr_back
// Sends the head group one byte per cycle unless stalled; marks run/text ends
// ----------------------------------------------------------------------------
`default_nettype none

module upr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire upr_pkg::group_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_byte,
  output logic                 last_of_run,
  output logic                 text_done
);

  logic [1:0] pos;
  logic       is_last;

  assign is_last     = (pos == head.cnt - 2'd1);
  assign out_valid   = head_valid;
  assign out_byte    = head.data[pos];
  assign last_of_run = is_last;
  assign text_done   = is_last && head.eot;
  assign pop         = out_valid && !out_stall && is_last;

  // Byte position within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (out_valid && !out_stall) begin
      pos <= is_last ? 2'd0 : pos + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/utf8_punctuation_replacer.sv */
// Result bytes are stored in the queue as a group before they are offered.
// Throughput: one input item per cycle while the queue is not full; the output
// side sends one byte per cycle unless stalled, so an item replaced by
// several bytes holds the back end for each of them. A queue of DEPTH byte
// groups lets the input run ahead meanwhile. Reset (synchronous) clears the
// held prefix count, the queue and the output byte position.
// ----------------------------------------------------------------------------
// utf8_punctuation_replacer
// Replaces full-width punctuation sequences in a UTF-8 byte stream with ASCII.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_punctuation_replacer #(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            text_done
);

  upr_pkg::push_req_t req;
  upr_pkg::group_t    head;
  logic               q_full;
  logic               head_valid;
  logic               pop;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  upr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .req         (req)
  );

  upr_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  upr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

  // A group is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(req.push && q_full))
    else $error("group pushed while queue full");

  // The end of the text always produces at least one byte
  a_eot_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |-> req.push)
    else $error("end of text item produced no bytes");

  // Queued groups are never empty
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.cnt != 2'd0))
    else $error("empty group in queue");

endmodule

`default_nettype wire
